// File: design/dat_pkg.sv
// shared types and constants for the delivery acknowledgement tracker
package dat_pkg;

  // send queue geometry
  localparam int PENDING_DEPTH = 16;
  localparam int PTR_W         = $clog2(PENDING_DEPTH);
  localparam int FILL_W        = $clog2(PENDING_DEPTH + 1);

  // at most this many results per ack or tick walk
  localparam int RESULT_LIMIT  = 16;
  localparam int RES_CNT_W     = $clog2(RESULT_LIMIT + 1);

  // configuration port
  localparam int          APB_ADDR_W    = 3;
  localparam logic        REG_TIMEOUT   = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // request codes
  localparam logic [2:0] REQ_SEND  = 3'd0;
  localparam logic [2:0] REQ_RECV  = 3'd1;
  localparam logic [2:0] REQ_EMIT  = 3'd2;
  localparam logic [2:0] REQ_ACK   = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_ASSIGNED = 3'd0;
  localparam logic [2:0] KIND_ACCEPTED = 3'd1;
  localparam logic [2:0] KIND_REJECTED = 3'd2;
  localparam logic [2:0] KIND_ACK_LIST = 3'd3;
  localparam logic [2:0] KIND_NO_ACKS  = 3'd4;
  localparam logic [2:0] KIND_SUCCESS  = 3'd5;
  localparam logic [2:0] KIND_FAILURE  = 3'd6;
  localparam logic [2:0] KIND_FULL_CLR = 3'd7;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] seq_in;
    logic [15:0] ack_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq_out;
    logic [15:0] count_out;
    logic        last;
  } rsp_t;

endpackage

// File: design/delivery_ack_tracker.sv
// delivery acknowledgement tracker: send queue, receive ack list and ack/timeout walks
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_t (req_type, seq_in, ack_count)
//  rsp      out        rsp_valid/rsp_ready  rsp_t (kind, seq_out, count_out, last)
//  apb      in/out     psel/penable/pready  timeout_ticks at byte address 0
//
// send, receive, emit, clear and unknown requests go from accept through exec and flush back to idle.
// ack and tick walks pass through the read and walk states for each queue entry visited, through the one
// read port of the send queue and the shared compare unit; at most 16 results.
// each result sits in a hold register until the next one or the end of the item is
// known, so the last flag is exact; a stalled rsp channel stalls the walk.
// synchronous reset empties the queue and zeroes the counters, timeout back to 100.
module delivery_ack_tracker import dat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state;

  // latched request
  logic [2:0]  op;
  logic [31:0] op_seq;
  logic [32:0] walk;
  logic [32:0] walk_end;

  logic [15:0] timeout;

  // send queue storage and its registered read port
  logic [31:0] mem_seq  [PENDING_DEPTH];
  logic [31:0] mem_time [PENDING_DEPTH];
  logic [31:0] rd_seq;
  logic [31:0] rd_time;

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;

  logic [31:0] next_out_seq;
  logic [31:0] next_exp_seq;
  logic [31:0] ack_first;
  logic [15:0] ack_pending;
  logic [31:0] now_ticks;

  // hold register for the newest result
  logic        hold_valid;
  logic [2:0]  hold_kind;
  logic [31:0] hold_seq;
  logic [15:0] hold_count;

  logic [RES_CNT_W-1:0] res_cnt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(PENDING_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    if (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT) begin
      prdata = {16'd0, timeout};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_W-1:2] == REG_TIMEOUT) begin
      timeout <= pwdata[15:0];
    end
  end

  // walk step: one compare of the head entry against the walk number or the age
  logic [32:0]          head_seq_ext;
  logic                 head_hit;
  logic                 head_older;
  logic [31:0]          head_age;
  logic                 walk_emit;
  logic [2:0]           walk_kind;
  logic [32:0]          walk_next;
  logic [FILL_W-1:0]    fill_after;
  logic [RES_CNT_W-1:0] cnt_after;
  logic                 walk_more;
  logic                 out_free;
  logic                 walk_stall;

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    head_seq_ext = {1'b0, rd_seq};
    head_hit     = head_seq_ext == walk;
    head_older   = head_seq_ext < walk;
    head_age     = now_ticks - rd_time;
    walk_kind    = KIND_FAILURE;
    walk_next    = walk;
    if (op == REQ_ACK) begin
      walk_emit = head_hit || head_older;
      if (head_hit) begin
        walk_kind = KIND_SUCCESS;
        walk_next = walk + 33'd1;
      end else if (!head_older) begin
        walk_next = (head_seq_ext < walk_end) ? head_seq_ext : walk_end;
      end
    end else begin
      walk_emit = head_age >= {16'd0, timeout};
    end
    fill_after = fill - FILL_W'(walk_emit);
    cnt_after  = res_cnt + RES_CNT_W'(walk_emit);
    if (op == REQ_ACK) begin
      walk_more = (walk_next < walk_end) && (fill_after != '0) &&
                  (cnt_after < RES_CNT_W'(RESULT_LIMIT));
    end else begin
      walk_more = walk_emit && (fill_after != '0) &&
                  (cnt_after < RES_CNT_W'(RESULT_LIMIT));
    end
    walk_stall = walk_emit && hold_valid && !out_free;
  end

  assign req_ready = (state == ST_IDLE);

  // new result into the hold register, the previous one goes out without last
  logic        new_valid;
  logic [2:0]  new_kind;
  logic [31:0] new_seq;
  logic [15:0] new_count;

  always_comb begin
    new_valid = 1'b0;
    new_kind  = KIND_FULL_CLR;
    new_seq   = '0;
    new_count = '0;
    case (state)
      ST_EXEC: begin
        case (op)
          REQ_SEND: begin
            new_valid = 1'b1;
            new_seq   = next_out_seq;
            new_kind  = (fill == FILL_W'(PENDING_DEPTH)) ? KIND_FULL_CLR : KIND_ASSIGNED;
          end
          REQ_RECV: begin
            new_valid = 1'b1;
            new_seq   = op_seq;
            new_kind  = (op_seq >= next_exp_seq) ? KIND_ACCEPTED : KIND_REJECTED;
          end
          REQ_EMIT: begin
            new_valid = 1'b1;
            if (ack_pending != '0) begin
              new_kind  = KIND_ACK_LIST;
              new_seq   = ack_first;
              new_count = ack_pending;
            end else begin
              new_kind  = KIND_NO_ACKS;
            end
          end
          REQ_CLEAR: begin
            new_valid = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_WALK: begin
        new_valid = walk_emit && !walk_stall;
        new_kind  = walk_kind;
        new_seq   = rd_seq;
      end
      default: begin
      end
    endcase
  end

  // hold register moves to the output: pushed out by a newer result, or the final flush
  logic rsp_load;
  logic rsp_last;

  assign rsp_last = (state == ST_FLUSH);
  assign rsp_load = (new_valid && hold_valid) || (rsp_last && hold_valid && out_free);

  // queue storage: written at the tail, read at the head
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && op == REQ_SEND && fill != FILL_W'(PENDING_DEPTH)) begin
      mem_seq[tail]  <= next_out_seq;
      mem_time[tail] <= now_ticks;
    end
    if (state == ST_READ) begin
      rd_seq  <= mem_seq[head];
      rd_time <= mem_time[head];
    end
  end

  // sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      tail         <= '0;
      fill         <= '0;
      next_out_seq <= '0;
      next_exp_seq <= '0;
      ack_first    <= '0;
      ack_pending  <= '0;
      now_ticks    <= '0;
      hold_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
      res_cnt      <= '0;
    end else begin
      // output register
      if (rsp_load) begin
        rsp       <= '{kind: hold_kind, seq_out: hold_seq, count_out: hold_count,
                       last: rsp_last};
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // result hand-over
      if (new_valid) begin
        hold_valid <= 1'b1;
        hold_kind  <= new_kind;
        hold_seq   <= new_seq;
        hold_count <= new_count;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op       <= req.req_type;
            op_seq   <= req.seq_in;
            walk     <= {1'b0, req.seq_in};
            walk_end <= {1'b0, req.seq_in} + {17'd0, req.ack_count};
            res_cnt  <= '0;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if ((op == REQ_ACK && walk < walk_end && fill != '0) ||
              (op == REQ_TICK && fill != '0)) begin
            state <= ST_READ;
          end else begin
            state <= ST_FLUSH;
          end
          case (op)
            REQ_SEND: begin
              if (fill != FILL_W'(PENDING_DEPTH)) begin
                tail         <= ptr_inc(tail);
                fill         <= fill + FILL_W'(1);
                next_out_seq <= next_out_seq + 32'd1;
              end
            end
            REQ_RECV: begin
              if (op_seq >= next_exp_seq) begin
                if (ack_pending == '0) begin
                  ack_first <= op_seq;
                end
                if (ack_pending != 16'hFFFF) begin
                  ack_pending <= ack_pending + 16'd1;
                end
                next_exp_seq <= op_seq + 32'd1;
              end
            end
            REQ_EMIT: begin
              ack_pending <= '0;
              ack_first   <= '0;
            end
            REQ_TICK: begin
              now_ticks <= now_ticks + 32'd1;
            end
            REQ_CLEAR: begin
              head         <= '0;
              tail         <= '0;
              fill         <= '0;
              next_out_seq <= '0;
              next_exp_seq <= '0;
              ack_first    <= '0;
              ack_pending  <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_READ: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (!walk_stall) begin
            walk    <= walk_next;
            res_cnt <= cnt_after;
            if (walk_emit) begin
              head <= ptr_inc(head);
              fill <= fill_after;
            end
            state <= walk_more ? ST_READ : ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !hold_valid)
    else $error("hold register still full while accepting an item");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(PENDING_DEPTH))
    else $error("send queue fill beyond depth");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CNT_W'(RESULT_LIMIT))
    else $error("walk produced too many results");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && walk_emit && !walk_stall) |-> fill != '0)
    else $error("pop from an empty send queue");

endmodule

// File: tb/tb.sv
// testbench for the delivery acknowledgement tracker: self-checking against a built-in predictor
module tb import dat_pkg::*; ();

  // unknown request codes, ignored by the block
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // time for ack and tick walks without results to finish, generous margin
  localparam int DRAIN_CYCLES = 60;

  // tracks queue, counters and ack list, holds the results still to come
  class delivery_predictor;
    logic [31:0] sent_seq [PENDING_DEPTH];
    logic [31:0] sent_tick [PENDING_DEPTH];
    int unsigned q_head;
    int unsigned q_tail;
    int unsigned q_fill;
    logic [31:0] next_out;
    logic [31:0] next_exp;
    logic [31:0] ack_first;
    logic [15:0] ack_pending;
    logic [31:0] now_tick;
    logic [15:0] timeout;
    rsp_t        item_results[$];
    rsp_t        expected_results[$];
    int unsigned errors;

    function new();
      q_head      = 0;
      q_tail      = 0;
      q_fill      = 0;
      next_out    = '0;
      next_exp    = '0;
      ack_first   = '0;
      ack_pending = '0;
      now_tick    = '0;
      timeout     = TIMEOUT_RESET;
      errors      = 0;
    endfunction

    function void add_result(logic [2:0] kind, logic [31:0] seq, logic [15:0] cnt);
      rsp_t r;
      r.kind       = kind;
      r.seq_out    = seq;
      r.count_out  = cnt;
      r.last       = 1'b0;
      item_results = {item_results, r};
    endfunction

    function void drop_head();
      q_head = (q_head + 1) % PENDING_DEPTH;
      q_fill--;
    endfunction

    // work out the results of one accepted item
    function void note_request(req_t r);
      logic [32:0] walk;
      logic [32:0] walk_end;
      logic [32:0] head_seq;
      logic [31:0] age;
      rsp_t        tail_res;
      item_results.delete();
      case (r.req_type)
        REQ_SEND: begin
          if (q_fill >= PENDING_DEPTH) begin
            add_result(KIND_FULL_CLR, next_out, '0);
          end else begin
            sent_seq[q_tail]  = next_out;
            sent_tick[q_tail] = now_tick;
            q_tail = (q_tail + 1) % PENDING_DEPTH;
            q_fill++;
            add_result(KIND_ASSIGNED, next_out, '0);
            next_out = next_out + 32'd1;
          end
        end
        REQ_RECV: begin
          if (r.seq_in >= next_exp) begin
            if (ack_pending == 16'd0) ack_first = r.seq_in;
            if (ack_pending != 16'hFFFF) ack_pending = ack_pending + 16'd1;
            next_exp = r.seq_in + 32'd1;
            add_result(KIND_ACCEPTED, r.seq_in, '0);
          end else begin
            add_result(KIND_REJECTED, r.seq_in, '0);
          end
        end
        REQ_EMIT: begin
          if (ack_pending != 16'd0) begin
            add_result(KIND_ACK_LIST, ack_first, ack_pending);
            ack_pending = '0;
            ack_first   = '0;
          end else begin
            add_result(KIND_NO_ACKS, '0, '0);
          end
        end
        REQ_ACK: begin
          // walk end is taken without wrap
          walk     = {1'b0, r.seq_in};
          walk_end = {1'b0, r.seq_in} + {17'd0, r.ack_count};
          while (walk < walk_end && q_fill > 0 && item_results.size() < RESULT_LIMIT) begin
            head_seq = {1'b0, sent_seq[q_head]};
            if (head_seq == walk) begin
              add_result(KIND_SUCCESS, sent_seq[q_head], '0);
              drop_head();
              walk = walk + 33'd1;
            end else if (head_seq < walk) begin
              add_result(KIND_FAILURE, sent_seq[q_head], '0);
              drop_head();
            end else begin
              walk = (head_seq < walk_end) ? head_seq : walk_end;
            end
          end
        end
        REQ_TICK: begin
          now_tick = now_tick + 32'd1;
          while (q_fill > 0 && item_results.size() < RESULT_LIMIT) begin
            age = now_tick - sent_tick[q_head];
            if (age < {16'd0, timeout}) break;
            add_result(KIND_FAILURE, sent_seq[q_head], '0);
            drop_head();
          end
        end
        REQ_CLEAR: begin
          q_head      = 0;
          q_tail      = 0;
          q_fill      = 0;
          next_out    = '0;
          next_exp    = '0;
          ack_first   = '0;
          ack_pending = '0;
          add_result(KIND_FULL_CLR, '0, '0);
        end
        default: ;
      endcase
      // flag the final result of the item
      if (item_results.size() > 0) begin
        tail_res      = item_results[item_results.size() - 1];
        tail_res.last = 1'b1;
        item_results[item_results.size() - 1] = tail_res;
      end
      expected_results = {expected_results, item_results};
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d seq_out %0h count_out %0d last %0b",
               got.kind, got.seq_out, got.count_out, got.last);
        errors++;
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.seq_out !== want.seq_out) begin
        $error("seq_out: expected %0h, got %0h", want.seq_out, got.seq_out);
        errors++;
      end
      if (got.count_out !== want.count_out) begin
        $error("count_out: expected %0d, got %0d", want.count_out, got.count_out);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req       = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;

  delivery_predictor tracker;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  delivery_ack_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("** delivery_ack_tracker: FAILED **");
    $finish;
  end

  // result side: random stalls and checking
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && rsp_valid && rsp_ready) tracker.check_response(rsp);
  end

  // present one item, hold it until accepted, then predict its results
  task automatic issue(input logic [2:0] code, input logic [31:0] seq, input logic [15:0] cnt);
    req_t r;
    r.req_type  = code;
    r.seq_in    = seq;
    r.ack_count = cnt;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    tracker.note_request(r);
  endtask

  // wait for all results, then let any walk without results finish
  task automatic settle();
    req_valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write of the timeout register, upper data bits random, then read back
  task automatic write_timeout(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TIMEOUT, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'd0, value}) begin
      $error("timeout_ticks: expected %0d, got %0d", value, prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.timeout = value;
  endtask

  // mostly sends, acks near the queue and receives near the expected number
  task automatic random_traffic(input int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    int unsigned burst;
    logic [31:0] seq;
    logic [15:0] cnt;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        burst = $urandom_range(1, 18);
        repeat (burst) issue(REQ_SEND, $urandom, 16'($urandom));
        done += burst;
      end else if (pick < 25) begin
        issue(REQ_SEND, $urandom, 16'($urandom));
        done++;
      end else if (pick < 45) begin
        if ($urandom_range(9) < 7)
          seq = tracker.next_exp + 32'($urandom_range(0, 8)) - 32'd4;
        else
          seq = $urandom;
        issue(REQ_RECV, seq, 16'($urandom));
        done++;
      end else if (pick < 55) begin
        issue(REQ_EMIT, $urandom, 16'($urandom));
        done++;
      end else if (pick < 80) begin
        if ($urandom_range(3) != 0) begin
          seq = tracker.next_out - 32'($urandom_range(0, tracker.q_fill + 3));
          cnt = 16'($urandom_range(0, 20));
        end else begin
          seq = $urandom;
          cnt = 16'($urandom);
        end
        issue(REQ_ACK, seq, cnt);
        done++;
      end else if (pick < 92) begin
        issue(REQ_TICK, $urandom, 16'($urandom));
        done++;
      end else if (pick < 95) begin
        issue(REQ_CLEAR, $urandom, 16'($urandom));
        done++;
      end else begin
        issue($urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B, $urandom, 16'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin
    logic [15:0]  phase_timeout [4];
    int unsigned  phase_idle [4];
    int unsigned  phase_stall [4];
    tracker = new();
    phase_timeout = '{16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(2, 50))};
    phase_idle    = '{0, 56, 0, 19};
    phase_stall   = '{0, 0, 56, 19};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ack list, receive order, walks and odd requests
    issue(REQ_EMIT, '0, '0);
    issue(REQ_RECV, 32'd5, '0);
    issue(REQ_RECV, 32'd6, '0);
    issue(REQ_RECV, 32'd3, '0);
    issue(REQ_EMIT, '0, '0);
    repeat (4) issue(REQ_SEND, '0, '0);
    issue(REQ_ACK, 32'd1, 16'd1);
    issue(REQ_ACK, '0, '0);
    issue(REQ_TICK, '0, '0);
    repeat (3) issue(REQ_SEND, 32'hFFFF_FFFF, 16'hFFFF);
    issue(REQ_ACK, 32'd2, 16'd2);
    issue(REQ_ACK, '0, 16'd10);
    issue(REQ_RECV, 32'hFFFF_FFFF, '0);
    issue(REQ_RECV, '0, '0);
    repeat (2) issue(REQ_SEND, '0, '0);
    // walk end beyond 32 bits: every entry is older
    issue(REQ_ACK, 32'hFFFF_FFFF, 16'hFFFF);
    issue(REQ_SPARE_A, '0, '0);
    issue(REQ_SPARE_B, 32'hFFFF_FFFF, 16'hFFFF);
    issue(REQ_CLEAR, '0, '0);
    issue(REQ_EMIT, '0, '0);

    // random phases, each with its own timeout and idling mix
    for (int p = 0; p < 4; p++) begin
      settle();
      write_timeout(phase_timeout[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      random_traffic(60);
    end

    settle();
    if (tracker.errors == 0)
      $display("** delivery_ack_tracker: PASSED **");
    else
      $display("** delivery_ack_tracker: FAILED **");
    $finish;
  end

endmodule
